FILE: src/ffra_pkg.sv
package ffra_pkg;

	// Fixed field widths of the stream payloads
	localparam int FIELD_W     = 52;
	localparam int IDX_IN_W    = 4;
	localparam int ALOG_W      = 6;
	localparam int CFG_W       = 5;
	localparam int IN_TDATA_W  = 168;
	localparam int OUT_TDATA_W = 56;

	// Bit offsets of the input fields inside s_axis_tdata
	localparam int OFS_IDX  = 0;
	localparam int OFS_BASE = OFS_IDX + IDX_IN_W;
	localparam int OFS_LEN  = OFS_BASE + FIELD_W;
	localparam int OFS_SIZE = OFS_LEN + FIELD_W;
	localparam int OFS_ALOG = OFS_SIZE + FIELD_W;

	// Command codes carried in s_axis_tuser
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_ALLOC = 1'b1;

	// Result status codes carried in m_axis_tuser
	localparam logic STS_OK   = 1'b0;
	localparam logic STS_FAIL = 1'b1;

	typedef enum logic [1:0] {
		RES_WRITE,
		RES_OK,
		RES_FAIL
	} res_kind_t;

	// Controller to datapath commands
	typedef struct packed {
		logic      capture;
		logic      prep;
		logic      scan_clr;
		logic      rd_en;
		logic      flush;
		logic      entry_wr;
		logic      wb_wr;
		logic      res_load;
		res_kind_t res_kind;
	} ctl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic is_alloc;
		logic bad;
		logic scan_end;
		logic pipe_busy;
		logic hit;
	} ctl_sts_t;

endpackage

FILE: src/ffra_ctrl.sv
module ffra_ctrl
	import ffra_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_valid,
	output logic     s_ready,
	input  logic     m_ready,
	output logic     m_valid,
	input  ctl_sts_t sts,
	output ctl_cmd_t ctl
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_SCAN,
		ST_WB,
		ST_DONE
	} state_t;

	state_t    state_q;
	res_kind_t kind_q;
	logic      m_valid_q;

	assign s_ready = (state_q == ST_IDLE);
	assign m_valid = m_valid_q;

	// Command decode
	always_comb begin
		ctl          = '0;
		ctl.res_kind = kind_q;
		case (state_q)
			ST_IDLE: begin
				ctl.capture = s_valid;
			end
			ST_PREP: begin
				if (sts.is_alloc) begin
					ctl.prep     = 1'b1;
					ctl.scan_clr = 1'b1;
				end else begin
					ctl.entry_wr = 1'b1;
				end
			end
			ST_SCAN: begin
				ctl.rd_en = !sts.bad && !sts.hit && !sts.scan_end;
				ctl.flush = sts.hit;
			end
			ST_WB: begin
				ctl.wb_wr = 1'b1;
			end
			ST_DONE: begin
				ctl.res_load = !m_valid_q || m_ready;
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

	// State, result kind and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			kind_q    <= RES_WRITE;
			m_valid_q <= 1'b0;
		end else begin
			if (ctl.res_load) begin
				m_valid_q <= 1'b1;
			end else if (m_ready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_valid) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					if (sts.is_alloc) begin
						state_q <= ST_SCAN;
					end else begin
						kind_q  <= RES_WRITE;
						state_q <= ST_DONE;
					end
				end
				ST_SCAN: begin
					if (sts.bad) begin
						kind_q  <= RES_FAIL;
						state_q <= ST_DONE;
					end else if (sts.hit) begin
						state_q <= ST_WB;
					end else if (sts.scan_end && !sts.pipe_busy) begin
						kind_q  <= RES_FAIL;
						state_q <= ST_DONE;
					end
				end
				ST_WB: begin
					kind_q  <= RES_OK;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (ctl.res_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: src/ffra_datapath.sv
module ffra_datapath
	import ffra_pkg::*;
#(
	parameter int MAX_REGIONS = 16,
	parameter int ADDR_BITS   = 52
)
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CFG_W-1:0]    cfg_wdata,
	input  logic                in_cmd,
	input  logic [IDX_IN_W-1:0] in_idx,
	input  logic [FIELD_W-1:0]  in_base,
	input  logic [FIELD_W-1:0]  in_len,
	input  logic [FIELD_W-1:0]  in_size,
	input  logic [ALOG_W-1:0]   in_alog,
	input  ctl_cmd_t            ctl,
	output ctl_sts_t            sts,
	output logic                res_status,
	output logic [FIELD_W-1:0]  res_addr
);

	localparam int A     = ADDR_BITS;
	localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
	localparam int CNT_W = $clog2(MAX_REGIONS + 1);
	localparam logic [8:0] MAXR9 = 9'(MAX_REGIONS);
	localparam logic [6:0] ABITS7 = 7'(ADDR_BITS);

	// Region table and per-entry valid bits
	logic [A-1:0]           base_mem [MAX_REGIONS];
	logic [A-1:0]           len_mem  [MAX_REGIONS];
	logic [MAX_REGIONS-1:0] valid_q;

	// Configuration and captured transaction
	logic [CFG_W-1:0]    region_count_q;
	logic                cmd_q;
	logic [IDX_IN_W-1:0] idx_q;
	logic [FIELD_W-1:0]  base_in_q;
	logic [FIELD_W-1:0]  len_in_q;
	logic [FIELD_W-1:0]  size_in_q;
	logic [ALOG_W-1:0]   alog_q;

	// Allocation setup
	logic [A-1:0] lowmask_q;
	logic [A-1:0] size_r_q;
	logic         bad_q;

	// Scan counter
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] limit;
	logic [8:0]       cnt9;
	logic [8:0]       lim9;

	// Scan pipeline
	logic             v_s1, v_s2, v_s3;
	logic [IDX_W-1:0] idx_s1, idx_s2, idx_s3;
	logic [A-1:0]     rd_base_s1, rd_len_s1;
	logic             rd_vld_s1;
	logic [A:0]       abase_s2, end_s2;
	logic [A-1:0]     abase_s3;
	logic             ovf_s3;
	logic [A:0]       newend_s3, end_s3;

	// Writeback
	logic [IDX_W-1:0] wb_idx_q;
	logic [A-1:0]     wb_base_q, wb_len_q, wb_addr_q;

	// Combinational helpers
	logic [63:0]      base_in64, len_in64, size_in64, addr64;
	logic [A-1:0]     base_in_a, len_in_a, size_a;
	logic [A-1:0]     mask_next;
	logic [A:0]       size_sum;
	logic [A-1:0]     b1, l1;
	logic [A:0]       len_diff;
	logic             hit;
	logic [8:0]       idx_wide;
	logic             idx_ok;
	logic             wr_en;
	logic [IDX_W-1:0] wr_idx;
	logic [A-1:0]     wr_base, wr_len;
	logic [IDX_W-1:0] rd_idx;

	// Width conversion of the fixed fields to the address width
	assign base_in64 = 64'(base_in_q);
	assign len_in64  = 64'(len_in_q);
	assign size_in64 = 64'(size_in_q);
	assign base_in_a = base_in64[A-1:0];
	assign len_in_a  = len_in64[A-1:0];
	assign size_a    = size_in64[A-1:0];
	assign addr64    = 64'(wb_addr_q);

	// Alignment mask and rounded size
	assign mask_next = ~({A{1'b1}} << alog_q);
	assign size_sum  = ({1'b0, size_a} + {1'b0, mask_next}) & ~{1'b0, mask_next};

	// Scan limit is the register clamped to the table depth
	assign cnt9   = 9'(region_count_q);
	assign lim9   = (cnt9 > MAXR9) ? MAXR9 : cnt9;
	assign limit  = lim9[CNT_W-1:0];
	assign rd_idx = cnt_q[IDX_W-1:0];

	// Entries never written read as zero
	assign b1 = rd_vld_s1 ? rd_base_s1 : '0;
	assign l1 = rd_vld_s1 ? rd_len_s1 : '0;

	// Fit test: aligned end of block must not pass the region end
	assign hit      = v_s3 && !ovf_s3 && (newend_s3 <= end_s3);
	assign len_diff = end_s3 - newend_s3;

	// Table write port: entry load or allocation writeback
	assign idx_wide = 9'(idx_q);
	assign idx_ok   = idx_wide < MAXR9;
	assign wr_en    = (ctl.entry_wr && idx_ok) || ctl.wb_wr;
	assign wr_idx   = ctl.wb_wr ? wb_idx_q : idx_wide[IDX_W-1:0];
	assign wr_base  = ctl.wb_wr ? wb_base_q : base_in_a;
	assign wr_len   = ctl.wb_wr ? wb_len_q : len_in_a;

	assign sts.is_alloc  = (cmd_q == CMD_ALLOC);
	assign sts.bad       = bad_q;
	assign sts.scan_end  = (cnt_q == limit);
	assign sts.pipe_busy = v_s1 || v_s2 || v_s3;
	assign sts.hit       = hit;

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_count_q <= '0;
			valid_q        <= '0;
			cnt_q          <= '0;
			v_s1           <= 1'b0;
			v_s2           <= 1'b0;
			v_s3           <= 1'b0;
		end else begin
			if (cfg_we) begin
				region_count_q <= cfg_wdata;
			end
			if (wr_en) begin
				valid_q[wr_idx] <= 1'b1;
			end
			if (ctl.scan_clr) begin
				cnt_q <= '0;
			end else if (ctl.rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end
			v_s1 <= ctl.rd_en && !ctl.flush;
			v_s2 <= v_s1 && !ctl.flush;
			v_s3 <= v_s2 && !ctl.flush;
		end
	end

	// Region table memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			base_mem[wr_idx] <= wr_base;
			len_mem[wr_idx]  <= wr_len;
		end
		if (ctl.rd_en) begin
			rd_base_s1 <= base_mem[rd_idx];
			rd_len_s1  <= len_mem[rd_idx];
			rd_vld_s1  <= valid_q[rd_idx];
			idx_s1     <= rd_idx;
		end
	end

	// Transaction capture, setup, scan stages, writeback and result
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q     <= in_cmd;
			idx_q     <= in_idx;
			base_in_q <= in_base;
			len_in_q  <= in_len;
			size_in_q <= in_size;
			alog_q    <= in_alog;
		end
		if (ctl.prep) begin
			lowmask_q <= mask_next;
			size_r_q  <= size_sum[A-1:0];
			bad_q     <= (size_a == '0) || (7'(alog_q) >= ABITS7) || size_sum[A];
		end
		// stage 2: aligned base and region end
		abase_s2 <= ({1'b0, b1} + {1'b0, lowmask_q}) & ~{1'b0, lowmask_q};
		end_s2   <= {1'b0, b1} + {1'b0, l1};
		idx_s2   <= idx_s1;
		// stage 3: end of the granted block
		abase_s3  <= abase_s2[A-1:0];
		ovf_s3    <= abase_s2[A];
		newend_s3 <= {1'b0, abase_s2[A-1:0]} + {1'b0, size_r_q};
		end_s3    <= end_s2;
		idx_s3    <= idx_s2;
		if (hit) begin
			wb_idx_q  <= idx_s3;
			wb_base_q <= newend_s3[A-1:0];
			wb_len_q  <= len_diff[A-1:0];
			wb_addr_q <= abase_s3;
		end
		if (ctl.res_load) begin
			case (ctl.res_kind)
				RES_OK: begin
					res_status <= STS_OK;
					res_addr   <= addr64[FIELD_W-1:0];
				end
				RES_FAIL: begin
					res_status <= STS_FAIL;
					res_addr   <= '0;
				end
				default: begin
					res_status <= STS_OK;
					res_addr   <= '0;
				end
			endcase
		end
	end

endmodule

FILE: src/first_fit_region_allocator_core.sv
// First-fit region allocator.
// Input stream (s_axis): one command per transaction. tuser selects a region
// table write or an allocation; tdata carries the entry index, base, length,
// request size and alignment exponent. Output stream (m_axis): one result per
// command, tuser is the status (set on a failed allocation), tdata the granted
// aligned address (zero on failure or on a write).
// cfg_we/cfg_wdata load the region count used by allocations; write it only
// while no command is in flight.
// An allocation scans the table entries below n, where n is the region
// count clamped to MAX_REGIONS; with n zero it scans nothing, and a bad
// request is rejected before the scan.
// One command is in work at a time; the scan reads one table entry per cycle
// through the single read port of the region table into a three-stage
// compare pipeline. A new command is accepted while the previous result
// still waits.
// Reset clears the region count and marks every table entry empty (reads as
// base 0, length 0). While the receiver stalls the result is held and the
// next result waits inside the block until the output register is taken.
module first_fit_region_allocator_core
	import ffra_pkg::*;
#(
	parameter int MAX_REGIONS = 16,
	parameter int ADDR_BITS   = 52
)
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_W-1:0]       cfg_wdata,     // region_count
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// region_index[3:0], region_base[55:4], region_length[107:56],
	// request_size[159:108], align_log2[165:160], zero pad
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input  logic [0:0]             s_axis_tuser,  // cmd
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // address[51:0], zero pad
	output logic [0:0]             m_axis_tuser   // status
);

	ctl_cmd_t           ctl;
	ctl_sts_t           sts;
	logic               res_status;
	logic [FIELD_W-1:0] res_addr;

	// Controller
	ffra_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.s_ready (s_axis_tready),
		.m_ready (m_axis_tready),
		.m_valid (m_axis_tvalid),
		.sts     (sts),
		.ctl     (ctl)
	);

	// Datapath with region table
	ffra_datapath #(
		.MAX_REGIONS (MAX_REGIONS),
		.ADDR_BITS   (ADDR_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_cmd     (s_axis_tuser[0]),
		.in_idx     (s_axis_tdata[OFS_IDX +: IDX_IN_W]),
		.in_base    (s_axis_tdata[OFS_BASE +: FIELD_W]),
		.in_len     (s_axis_tdata[OFS_LEN +: FIELD_W]),
		.in_size    (s_axis_tdata[OFS_SIZE +: FIELD_W]),
		.in_alog    (s_axis_tdata[OFS_ALOG +: ALOG_W]),
		.ctl        (ctl),
		.sts        (sts),
		.res_status (res_status),
		.res_addr   (res_addr)
	);

	// Result packing
	assign m_axis_tdata = {{(OUT_TDATA_W - FIELD_W){1'b0}}, res_addr};
	assign m_axis_tuser = res_status;

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import ffra_pkg::*;

	localparam int NREG     = 16;
	localparam int SETTLE   = 30;   // cycles after the last result before a register write
	localparam int HOLD_CYC = 400;  // long output stall
	localparam int PHASE_N  = 70;   // random commands per phase

	typedef struct {
		logic                cmd;
		logic [IDX_IN_W-1:0] idx;
		logic [FIELD_W-1:0]  base;
		logic [FIELD_W-1:0]  len;
		logic [FIELD_W-1:0]  size;
		logic [ALOG_W-1:0]   alog;
	} alloc_cmd_t;

	typedef struct {
		logic               status;
		logic [FIELD_W-1:0] addr;
	} grant_t;

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   cfg_we        = 1'b0;
	logic [CFG_W-1:0]       cfg_wdata     = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
	logic [0:0]             s_axis_tuser  = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic [0:0]             m_axis_tuser;

	// Commands waiting to be sent, results still owed by the block
	alloc_cmd_t cmd_q[$];
	grant_t     grant_q[$];

	// Own copy of the region table and the count register
	logic [FIELD_W-1:0] tbl_base[NREG];
	logic [FIELD_W-1:0] tbl_len[NREG];
	logic [CFG_W-1:0]   model_count = '0;

	logic in_fire  = 1'b0;
	logic out_fire = 1'b0;
	bit   tx_idle  = 1'b1;
	bit   rx_idle  = 1'b1;
	bit   hold_go  = 1'b0;
	bit   rx_block = 1'b0;
	int   tx_gap   = 0;
	int   n_err    = 0;
	int   n_wr     = 0;
	int   n_hit    = 0;
	int   n_miss   = 0;

	first_fit_region_allocator_core #(
		.MAX_REGIONS(NREG),
		.ADDR_BITS  (FIELD_W)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always #10 clk = ~clk;

	initial begin
		for (int i = 0; i < NREG; i++) begin
			tbl_base[i] = '0;
			tbl_len[i]  = '0;
		end
	end

	// First-fit allocation on the local table; returns the grant the block owes
	function automatic grant_t apply_cmd(alloc_cmd_t c);
		grant_t           g;
		logic [FIELD_W:0] mask, size_r, abase, gap, room;
		int               lim;
		g.status = STS_OK;
		g.addr   = '0;
		if (c.cmd == CMD_WRITE) begin
			tbl_base[c.idx] = c.base;
			tbl_len[c.idx]  = c.len;
			return g;
		end
		g.status = STS_FAIL;
		if (c.size == '0 || c.alog >= FIELD_W)
			return g;
		mask   = ({{FIELD_W{1'b0}}, 1'b1} << c.alog) - 1'b1;
		size_r = ({1'b0, c.size} + mask) & ~mask;
		// rounded size no longer fits the address space
		if (size_r[FIELD_W])
			return g;
		lim = (model_count > NREG) ? NREG : int'(model_count);
		for (int i = 0; i < lim; i++) begin
			abase = ({1'b0, tbl_base[i]} + mask) & ~mask;
			if (abase[FIELD_W])
				continue;
			gap = abase - {1'b0, tbl_base[i]};
			// alignment gap runs past the end of the region
			if (gap > {1'b0, tbl_len[i]})
				continue;
			room = {1'b0, tbl_len[i]} - gap;
			if (room < size_r)
				continue;
			tbl_base[i] = abase[FIELD_W-1:0] + size_r[FIELD_W-1:0];
			tbl_len[i]  = room[FIELD_W-1:0] - size_r[FIELD_W-1:0];
			g.status    = STS_OK;
			g.addr      = abase[FIELD_W-1:0];
			return g;
		end
		return g;
	endfunction

	// Value of random bit length, up to top bits
	function automatic logic [FIELD_W-1:0] rand_span(int unsigned top);
		logic [63:0] v;
		int unsigned nb;
		v  = {$urandom, $urandom};
		nb = $urandom_range(0, top);
		v &= (64'd1 << nb) - 64'd1;
		return v[FIELD_W-1:0];
	endfunction

	// Mostly well-formed writes and allocations, some pure noise
	function automatic alloc_cmd_t rand_cmd(int unsigned wr_pct);
		alloc_cmd_t c;
		c.cmd  = 1'($urandom);
		c.idx  = IDX_IN_W'($urandom);
		c.base = FIELD_W'({$urandom, $urandom});
		c.len  = FIELD_W'({$urandom, $urandom});
		c.size = FIELD_W'({$urandom, $urandom});
		c.alog = ALOG_W'($urandom);
		if ($urandom_range(0, 99) < 8)
			return c;
		c.cmd = ($urandom_range(0, 99) < wr_pct) ? CMD_WRITE : CMD_ALLOC;
		if (c.cmd == CMD_WRITE) begin
			c.base = rand_span(FIELD_W);
			c.len  = rand_span(FIELD_W);
		end else begin
			c.size = rand_span(36);
			c.alog = ALOG_W'(($urandom_range(0, 9) < 8) ? $urandom_range(0, 16)
				: $urandom_range(0, 63));
		end
		return c;
	endfunction

	task automatic push_write(logic [IDX_IN_W-1:0] idx, logic [FIELD_W-1:0] base,
			logic [FIELD_W-1:0] len);
		alloc_cmd_t c;
		c      = rand_cmd(0);
		c.cmd  = CMD_WRITE;
		c.idx  = idx;
		c.base = base;
		c.len  = len;
		cmd_q.push_back(c);
	endtask

	task automatic push_alloc(logic [FIELD_W-1:0] size, logic [ALOG_W-1:0] alog);
		alloc_cmd_t c;
		c      = rand_cmd(0);
		c.cmd  = CMD_ALLOC;
		c.size = size;
		c.alog = alog;
		cmd_q.push_back(c);
	endtask

	// Wait until everything sent has come back, then let the block settle
	task automatic drain();
		do begin
			@(posedge clk);
			#1;
		end while (cmd_q.size() != 0 || s_axis_tvalid || in_fire || grant_q.size() != 0);
		repeat (SETTLE) @(posedge clk);
		#1;
	endtask

	task automatic set_count(logic [CFG_W-1:0] v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
		#1;
	endtask

	// Command driver: one transaction at a time, random gap after each while tx_idle is set
	always @(negedge clk) begin : cmd_drv
		alloc_cmd_t            cur;
		grant_t                g;
		logic [IN_TDATA_W-1:0] d;
		logic                  v_next;
		v_next = s_axis_tvalid;
		if (in_fire) begin
			g = apply_cmd(cur);
			grant_q.push_back(g);
			if (cur.cmd == CMD_WRITE)
				n_wr++;
			else if (g.status == STS_OK)
				n_hit++;
			else
				n_miss++;
			v_next = 1'b0;
			tx_gap = tx_idle ? int'($urandom_range(0, 17)) : 0;
		end
		if (arst_n && !v_next) begin
			if (tx_gap > 0)
				tx_gap--;
			else if (cmd_q.size() != 0) begin
				cur = cmd_q.pop_front();
				d   = '0;
				d[OFS_IDX  +: IDX_IN_W] = cur.idx;
				d[OFS_BASE +: FIELD_W]  = cur.base;
				d[OFS_LEN  +: FIELD_W]  = cur.len;
				d[OFS_SIZE +: FIELD_W]  = cur.size;
				d[OFS_ALOG +: ALOG_W]   = cur.alog;
				s_axis_tdata <= d;
				s_axis_tuser <= cur.cmd;
				v_next = 1'b1;
			end
		end
		s_axis_tvalid <= v_next;
	end

	// Input side acceptance and register writes
	always @(posedge clk) begin
		in_fire <= arst_n && s_axis_tvalid && s_axis_tready;
		if (arst_n && cfg_we)
			model_count = cfg_wdata;
	end

	// Result receiver: random stall after each result while rx_idle is set, plus the long hold
	always @(negedge clk) begin : rx_drv
		int rx_wait;
		if (out_fire)
			rx_wait = rx_idle ? int'($urandom_range(0, 17)) : 0;
		if (rx_block)
			m_axis_tready <= 1'b0;
		else if (rx_wait > 0) begin
			rx_wait--;
			m_axis_tready <= 1'b0;
		end else
			m_axis_tready <= 1'b1;
	end

	initial begin : rx_hold
		wait (hold_go);
		@(posedge clk);
		rx_block = 1'b1;
		repeat (HOLD_CYC) @(posedge clk);
		rx_block = 1'b0;
	end

	// Result monitor: compare each transaction with the oldest grant owed
	always @(posedge clk) begin : grant_mon
		grant_t g;
		out_fire <= arst_n && m_axis_tvalid && m_axis_tready;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (grant_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, got status %0d address %h",
					$time, m_axis_tuser, m_axis_tdata);
				n_err++;
			end else begin
				g = grant_q.pop_front();
				if (m_axis_tuser[0] !== g.status) begin
					$display("%0t: status expected %0d, got %0d", $time, g.status, m_axis_tuser);
					n_err++;
				end
				if (m_axis_tdata[FIELD_W-1:0] !== g.addr) begin
					$display("%0t: address expected %h, got %h", $time, g.addr,
						m_axis_tdata[FIELD_W-1:0]);
					n_err++;
				end
				if (m_axis_tdata[OUT_TDATA_W-1:FIELD_W] !== '0) begin
					$display("%0t: tdata pad expected 0, got %h", $time,
						m_axis_tdata[OUT_TDATA_W-1:FIELD_W]);
					n_err++;
				end
			end
		end
	end

	initial begin : stim
		logic [CFG_W-1:0] counts[9];
		counts = '{5'd16, 5'd31, 5'd0, 5'd1, 5'd7, 5'd16, 5'd12, 5'd31, 5'd16};
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		#1;

		// count still at reset: nothing is scanned
		push_alloc(52'd1, 6'd0);
		drain();
		set_count(5'd16);

		// gap past region end, base rounding overflow, empty entry, wrap at the top
		push_write(4'd0, 52'h0_0000_0000_1001, 52'h10);
		push_write(4'd1, 52'hF_FFFF_FFFF_F000, 52'hFFF);
		push_write(4'd2, 52'h0, 52'h0);
		push_write(4'd3, 52'h100, 52'hFF);
		push_write(4'd15, 52'hF_FFFF_FFFF_FFF0, 52'hF_FFFF_FFFF_FFFF);
		push_alloc(52'd0, 6'd0);
		push_alloc(52'd1, 6'd52);
		push_alloc(52'd1, 6'd63);
		push_alloc(52'hF_FFFF_FFFF_FFFF, 6'd1);
		push_alloc(52'hF_FFFF_FFFF_FFFF, 6'd0);
		push_alloc(52'd1, 6'd12);
		push_alloc(52'h10, 6'd4);
		push_alloc(52'h10, 6'd0);
		push_alloc(52'h8000_0000_0000, 6'd4);
		push_alloc(52'd1, 6'd51);
		push_alloc(52'd1, 6'd0);
		push_write(4'd4, 52'h0, 52'hF_FFFF_FFFF_FFFF);
		push_alloc(52'h8_0000_0000_0000, 6'd51);
		push_alloc(52'h8_0000_0000_0000, 6'd51);
		push_alloc(52'h1, 6'd3);
		drain();

		// random phases over a spread of region counts
		foreach (counts[p]) begin
			set_count(counts[p]);
			tx_idle = (p % 3 != 2) && ($urandom_range(0, 3) != 0);
			rx_idle = (p % 3 != 2);
			if (p == 5) begin
				tx_idle = 1'b0;
				hold_go = 1'b1;
			end
			for (int k = 0; k < PHASE_N; k++)
				cmd_q.push_back(rand_cmd((k < 12) ? 80 : 25));
			drain();
		end

		$display("%0d table writes, %0d grants and %0d refusals checked",
			n_wr, n_hit, n_miss);
		$display("region counts from 0 to 31, random gaps both sides, one long output stall");
		if (n_err == 0 && grant_q.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin : watchdog
		#10_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
